### design/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared constants, codes and types for the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int SLOT_DEPTH = 1024;
  localparam int IDX_W      = $clog2(SLOT_DEPTH);
  localparam int SZ_W       = IDX_W + 1;          // holds an effective size up to SLOT_DEPTH
  localparam int HANDLE_W   = 16;
  localparam int KEY_W      = 31;
  localparam int DVD_W      = KEY_W + 1;          // key plus one
  localparam int CFG_W      = 11;
  localparam int CNT_W      = 11;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int SIZE_RESET = 1021;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FILL_LIMIT = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [SZ_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [SZ_W-1:0] rem;
  } mod_rsp_t;

endpackage

### design/qpht_mod.sv
// ----------------------------------------------------------------------------
// qpht_mod
// Iterative remainder unit: reduces a key-plus-one word modulo the table
// size, four dividend bits per cycle by restoring compare and subtract.
// ----------------------------------------------------------------------------
module qpht_mod (
  input  logic                clk,
  input  logic                rst_n,
  input  qpht_pkg::mod_req_t  req,
  output qpht_pkg::mod_rsp_t  rsp
);
  import qpht_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int NUM_CYC   = DVD_W / STEP_BITS;
  localparam int CYC_W     = $clog2(NUM_CYC);

  logic             busy_r;
  logic             done_r;
  logic [CYC_W-1:0] cyc_r;
  logic [DVD_W-1:0] dvd_r;
  logic [SZ_W-1:0]  div_r;
  logic [SZ_W-1:0]  rem_r;
  logic [DVD_W-1:0] dvd_nxt;
  logic [SZ_W-1:0]  rem_nxt;

  always_comb begin
    logic [SZ_W:0]    t;
    logic [SZ_W-1:0]  r;
    logic [DVD_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {r, d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[SZ_W-1:0];
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cyc_r == CYC_W'(NUM_CYC - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cyc_r  <= '0;
      end else if (busy_r) begin
        cyc_r <= cyc_r + 1'b1;
        if (cyc_r == CYC_W'(NUM_CYC - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### design/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing table of link handles keyed by address, probed
// quadratically from the home slot (key + 1) mod size.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in_     | request   | in_valid/in_stall  | req_type, key_addr, link_handle
//   out_    | response  | out_valid/out_stall| status, found_handle, slot_index
//   cfg_    | write     | cfg_wr_en          | cfg_wr_data (table size)
//
// One request at a time. A probed request waits in the remainder unit for
// the home slot, then each probe is a slot memory read followed by a compare
// and write back, then the result moves to the output register. Refused
// inserts and unknown requests go straight to the output register state.
// After reset a clearing pass over all 1024 slots empties the slot memory
// while in_stall stays high. A stalled response waits in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [qpht_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [qpht_pkg::REQ_W-1:0]    in_req_type,
  input  logic [qpht_pkg::KEY_W-1:0]    in_key_addr,
  input  logic [qpht_pkg::HANDLE_W-1:0] in_link_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [qpht_pkg::STAT_W-1:0]   out_status,
  output logic [qpht_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [qpht_pkg::IDX_W-1:0]    out_slot_index
);
  import qpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MODW  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    clr_idx_r;
  logic [CFG_W-1:0]    tsz_r;
  logic [CNT_W-1:0]    count_r;
  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [IDX_W-1:0]    pos_r;
  logic [IDX_W-1:0]    inc_r;
  logic [SZ_W-1:0]     pcnt_r;
  logic [STAT_W-1:0]   res_status_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic [IDX_W-1:0]    res_slot_r;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [IDX_W-1:0]    out_slot_r;

  entry_t              mem [SLOT_DEPTH];
  entry_t              rd_data_r;
  entry_t              wr_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;

  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  logic [SZ_W-1:0]     eff_size;
  logic [SZ_W+1:0]     fill_limit;
  logic                fill_ok;
  logic                accept;
  logic                want_empty;
  logic                hit;
  logic                last_probe;
  logic                load_out;
  logic [SZ_W-1:0]     pos_sum;
  logic [IDX_W-1:0]    pos_step;
  logic [SZ_W-1:0]     inc_sum;
  logic [IDX_W-1:0]    inc_step;

  // Clamp the loaded size into 1..SLOT_DEPTH
  always_comb begin
    if (tsz_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (32'(tsz_r) > 32'(SLOT_DEPTH)) begin
      eff_size = SZ_W'(SLOT_DEPTH);
    end else begin
      eff_size = SZ_W'(tsz_r);
    end
  end

  assign fill_limit = ({2'b00, eff_size} + {1'b0, eff_size, 1'b0}) >> 2;
  assign fill_ok    = (32'(count_r) + 32'd1) <= 32'(fill_limit);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign want_empty = (req_r == REQ_INSERT);
  assign hit        = want_empty ? !rd_data_r.valid
                                 : (rd_data_r.valid && rd_data_r.key == key_r);
  assign last_probe = (pcnt_r == eff_size - 1'b1);

  // Next probe: pos + (2i-1) mod size, with the odd increment kept reduced
  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, inc_r};
    if (pos_sum >= eff_size) begin
      pos_sum = pos_sum - eff_size;
    end
    pos_step = pos_sum[IDX_W-1:0];
    inc_sum  = {1'b0, inc_r} + SZ_W'(2);
    if (inc_sum >= eff_size) begin
      inc_sum = inc_sum - eff_size;
    end
    inc_step = inc_sum[IDX_W-1:0];
  end

  assign mod_req.start    = accept && (((in_req_type == REQ_INSERT) && fill_ok) ||
                                       (in_req_type == REQ_FETCH) ||
                                       (in_req_type == REQ_REMOVE));
  assign mod_req.dividend = {1'b0, in_key_addr} + DVD_W'(1);
  assign mod_req.divisor  = eff_size;

  qpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = rd_data_r;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else if (state_r == S_CHECK && hit) begin
      if (req_r == REQ_INSERT) begin
        wr_en   = 1'b1;
        wr_data = '{valid: 1'b1, key: key_r, value: hdl_r};
      end else if (req_r == REQ_REMOVE) begin
        wr_en         = 1'b1;
        wr_data.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[pos_r];
  end

  assign load_out = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == IDX_W'(SLOT_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (mod_req.start) state_nxt = S_MODW;
        else if (accept)   state_nxt = S_RESP;
      end
      S_MODW: begin
        if (mod_rsp.done) state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (hit || last_probe) state_nxt = S_RESP;
        else                   state_nxt = S_READ;
      end
      S_RESP: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      tsz_r       <= CFG_W'(SIZE_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_wr_en) begin
        tsz_r <= cfg_wr_data;
      end
      if (state_r == S_CHECK && hit) begin
        if (req_r == REQ_INSERT) begin
          count_r <= count_r + 1'b1;
        end else if (req_r == REQ_REMOVE && count_r != '0) begin
          count_r <= count_r - 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and probe registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= in_req_type;
      key_r        <= in_key_addr;
      hdl_r        <= in_link_handle;
      res_handle_r <= '0;
      res_slot_r   <= '0;
      if (in_req_type == REQ_INSERT && !fill_ok) begin
        res_status_r <= ST_FILL_LIMIT;
      end else begin
        res_status_r <= ST_NOT_FOUND;
      end
    end
    if (state_r == S_MODW && mod_rsp.done) begin
      pos_r  <= mod_rsp.rem[IDX_W-1:0];
      inc_r  <= IDX_W'(1);
      pcnt_r <= '0;
    end
    if (state_r == S_CHECK) begin
      if (hit) begin
        res_status_r <= ST_OK;
        res_slot_r   <= pos_r;
        res_handle_r <= (req_r == REQ_INSERT) ? '0 : rd_data_r.value;
      end else if (last_probe) begin
        res_status_r <= want_empty ? ST_NO_EMPTY : ST_NOT_FOUND;
      end else begin
        pos_r  <= pos_step;
        inc_r  <= inc_step;
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_handle_r;
  assign out_slot_index   = out_slot_r;

endmodule

### design/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks on the hash table: response hold, reset behaviour,
// one request in flight and clean payload on failed requests.
// ----------------------------------------------------------------------------
module qpht_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [qpht_pkg::STAT_W-1:0]   out_status,
  input logic [qpht_pkg::HANDLE_W-1:0] out_found_handle,
  input logic [qpht_pkg::IDX_W-1:0]    out_slot_index
);
  import qpht_pkg::*;

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_found_handle) && $stable(out_slot_index))
    else $error("stalled response changed or dropped");

  // Leave reset with no response pending and requests held off for the clear
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("response or request ready straight after reset");

  // Take one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Failed requests carry no handle and no slot
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_found_handle == '0) &&
                                           (out_slot_index == '0))
    else $error("failed response carries a handle or slot");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_found_handle (out_found_handle),
  .out_slot_index   (out_slot_index)
);
